### src/soct_pkg.sv
// ----------------------------------------------------------------------------
// soct_pkg: shared types and constants for the complementary tilt filter
// Holds the beat structs, the function codes, the register indexes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package soct_pkg;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_INIT   = 2'd1,
        FUNC_ZERO   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    localparam logic [1:0] REG_GAIN_X   = 2'd0;
    localparam logic [1:0] REG_GAIN_Y   = 2'd1;
    localparam logic [1:0] REG_TILT     = 2'd2;
    localparam logic [1:0] REG_MIN_VERT = 2'd3;

    localparam int TAB_LEN = 24;
    localparam logic signed [31:0] PI_Q28 = 32'sd843314857;

    typedef struct packed {
        logic [1:0]          func;
        logic signed [15:0]  gyro_x;
        logic signed [15:0]  gyro_y;
        logic signed [15:0]  accel_x;
        logic signed [15:0]  accel_y;
        logic signed [15:0]  accel_z;
        logic [15:0]         time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
    } t_out_beat;

    // Lane control from the top level.
    typedef struct packed {
        logic start;
        logic func_update;
        logic func_init;
        logic func_zero;
    } t_lane_ctl;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0: r = 32'sd210828714;   5'd1: r = 32'sd124459457;
            5'd2: r = 32'sd65760959;    5'd3: r = 32'sd33381290;
            5'd4: r = 32'sd16755422;    5'd5: r = 32'sd8385879;
            5'd6: r = 32'sd4193963;     5'd7: r = 32'sd2097109;
            5'd8: r = 32'sd1048571;     5'd9: r = 32'sd524287;
            5'd10: r = 32'sd262144;     5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;      5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;      5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;       5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;       5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;        5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;         5'd23: r = 32'sd32;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### src/second_order_complementary_tilt.sv
// ----------------------------------------------------------------------------
// second_order_complementary_tilt: two-axis complementary tilt filter
// Each axis lane holds its rate integrator and angle. An update beat runs
// through the per-lane CORDIC, which does one rotation per cycle, and then a
// multiply sequence; init, zero and unused codes are answered from idle.
// One beat is worked at a time; the result sits in an output register, and
// a new beat is taken only once that result has been taken.
// ----------------------------------------------------------------------------
module second_order_complementary_tilt #(
    parameter int CORDIC_STEPS = 16,
    parameter int AXES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  soct_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output soct_pkg::t_out_beat  o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_gain [2];
    logic [14:0] r_tilt;
    logic signed [15:0] r_min_vert;
    soct_pkg::t_in_beat r_in;
    logic r_busy, r_start;
    logic [2:0] r_done;
    logic [2:0] done;
    logic signed [31:0] ang [3];
    soct_pkg::t_lane_ctl ctl;
    logic signed [15:0] gy [3], ac [3];

    assign gy[0] = r_in.gyro_x,  gy[1] = r_in.gyro_y,  gy[2] = '0;
    assign ac[0] = r_in.accel_x, ac[1] = r_in.accel_y, ac[2] = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0]  <= 16'd256;
            r_gain[1]  <= 16'd256;
            r_tilt     <= 15'd12868;
            r_min_vert <= 16'sd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                soct_pkg::REG_GAIN_X:   r_gain[0]  <= i_cfg_data;
                soct_pkg::REG_GAIN_Y:   r_gain[1]  <= i_cfg_data;
                soct_pkg::REG_TILT:     r_tilt     <= i_cfg_data[14:0];
                soct_pkg::REG_MIN_VERT: r_min_vert <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl.start       = r_start;
    assign ctl.func_update = r_in.func == soct_pkg::FUNC_UPDATE;
    assign ctl.func_init   = r_in.func == soct_pkg::FUNC_INIT;
    assign ctl.func_zero   = r_in.func == soct_pkg::FUNC_ZERO;

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_lane
            if (a < AXES && a < 2) begin : g_on
                soct_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane (
                    .i_clk, .i_rst_n, .i_ctl(ctl),
                    .i_gyro(gy[a]), .i_acc(ac[a]), .i_accz(r_in.accel_z),
                    .i_dt(r_in.time_step), .i_gain(r_gain[a]),
                    .i_tilt(r_tilt), .i_min_vert(r_min_vert),
                    .o_done(done[a]), .o_angle(ang[a]));
            end else begin : g_off
                assign done[a] = 1'b1;
                assign ang[a]  = '0;
            end
        end
    endgenerate

    function automatic logic signed [15:0] out_sat(input logic signed [31:0] v);
        logic signed [20:0] s;
        s = 21'(v >>> 11);
        if (s > 21'sd32767) return 16'sh7fff;
        if (s < -21'sd32768) return 16'sh8000;
        return s[15:0];
    endfunction

    assign o_ready = !r_busy && !o_valid;

    // Merge: wait until every lane has reported, then register the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= 1'b0;
            r_done  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_valid && o_ready) begin
                r_in    <= i_data;
                r_busy  <= 1'b1;
                r_start <= 1'b1;
                r_done  <= '0;
            end else if (r_busy && !r_start) begin
                if (&(r_done | done)) begin
                    r_busy  <= 1'b0;
                    o_valid <= 1'b1;
                    o_data.angle_x <= out_sat(ang[0]);
                    o_data.angle_y <= out_sat(ang[1]);
                end else begin
                    r_done <= r_done | done;
                end
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("accept while busy");
    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start) else $error("start held");
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_busy)) else $error("result without work");
`endif

endmodule

### src/soct_lane.sv
// ----------------------------------------------------------------------------
// soct_lane: one axis of the complementary tilt filter
// Runs a one-step-a-cycle vectoring CORDIC for atan2, then a short
// multiply sequence that updates the rate integrator and the angle.
// ----------------------------------------------------------------------------
module soct_lane #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  soct_pkg::t_lane_ctl      i_ctl,
    input  logic signed [15:0]       i_gyro,
    input  logic signed [15:0]       i_acc,
    input  logic signed [15:0]       i_accz,
    input  logic [15:0]              i_dt,
    input  logic [15:0]              i_gain,
    input  logic [14:0]              i_tilt,
    input  logic signed [15:0]       i_min_vert,
    output logic                     o_done,
    output logic signed [31:0]       o_angle
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CORD = 7'b0000010,
        S_ERR  = 7'b0000100,
        S_KK   = 7'b0001000,
        S_MUL1 = 7'b0010000,
        S_MUL2 = 7'b0100000,
        S_MUL3 = 7'b1000000
    } t_state;

    localparam int STEPS = (CORDIC_STEPS < soct_pkg::TAB_LEN) ? CORDIC_STEPS
                                                              : soct_pkg::TAB_LEN;

    t_state r_state, n_state;
    logic [4:0] r_step;
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic r_use;
    logic signed [31:0] r_rate, r_angle;
    logic signed [33:0] r_err;
    // k squared needs all 32 bits unsigned.
    logic [31:0] r_kk;
    logic signed [63:0] r_p;
    logic signed [63:0] r_ek;

    logic signed [33:0] dx, dy;
    logic signed [31:0] at;
    logic signed [63:0] lim;
    logic valid_acc;

    assign dx = r_cy >>> r_step;
    assign dy = r_cx >>> r_step;
    assign at = soct_pkg::atan_entry(r_step);
    assign lim = 64'(i_tilt) <<< 11;
    assign valid_acc = !((i_accz < i_min_vert) || (64'(r_angle) > lim) ||
                         (64'(r_angle) < -lim));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_ctl.start && i_ctl.func_update) n_state = S_CORD;
            S_CORD: if (r_step == 5'(STEPS - 1)) n_state = S_ERR;
            S_ERR:  n_state = S_KK;
            S_KK:   n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= '0;
            r_angle <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_use  <= (i_acc != 0) || (i_accz != 0);
                    if (i_accz < 0) begin
                        r_cx <= -(34'(i_accz) <<< 16);
                        r_cy <= -(34'(i_acc) <<< 16);
                        r_cz <= (i_acc >= 0) ? 34'(soct_pkg::PI_Q28)
                                             : -34'(soct_pkg::PI_Q28);
                    end else begin
                        r_cx <= 34'(i_accz) <<< 16;
                        r_cy <= 34'(i_acc) <<< 16;
                        r_cz <= '0;
                    end
                    if (i_ctl.start) begin
                        if (i_ctl.func_init) begin
                            r_angle <= 32'(i_acc) <<< 12;
                            r_rate  <= -(32'(i_gyro) <<< 12);
                            o_done  <= 1'b1;
                        end else if (i_ctl.func_zero) begin
                            r_angle <= '0;
                            o_done  <= 1'b1;
                        end else if (!i_ctl.func_update) begin
                            o_done  <= 1'b1;
                        end
                    end
                end
                S_CORD: begin
                    r_step <= r_step + 5'd1;
                    if (r_cy > 0) begin
                        r_cx <= r_cx + dx;
                        r_cy <= r_cy - dy;
                        r_cz <= r_cz + 34'(at);
                    end else begin
                        r_cx <= r_cx - dx;
                        r_cy <= r_cy + dy;
                        r_cz <= r_cz - 34'(at);
                    end
                end
                S_ERR: begin
                    if (valid_acc) begin
                        r_err <= (r_use ? (r_cz >>> 4) : 34'sd0) - 34'(r_angle);
                    end else begin
                        r_err <= '0;
                    end
                end
                S_KK: begin
                    r_kk <= $signed({16'd0, i_gain}) * $signed({16'd0, i_gain});
                    r_ek <= 64'(r_err) * 64'($signed({1'b0, i_gain}));
                end
                S_MUL1: begin
                    // e*k*k, then scaled by dt on the next step
                    r_p <= (64'(r_err) * 64'($signed({1'b0, r_kk}))) >>> 16;
                end
                S_MUL2: begin
                    r_rate <= soct_pkg::sat32(64'(r_rate) +
                              ((r_p * 64'($signed({1'b0, i_dt}))) >>> 16));
                    r_ek <= r_ek >>> 7;
                end
                S_MUL3: begin
                    r_angle <= soct_pkg::sat32(64'(r_angle) +
                               (((64'(r_rate) + r_ek + (64'(i_gyro) <<< 12)) *
                                 64'($signed({1'b0, i_dt}))) >>> 16));
                    o_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_angle = r_angle;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_cord_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ERR |=> r_state == S_KK) else $error("sequence broken");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
`endif

endmodule
